>>> sv/lobm_pkg.sv
package lobm_pkg;

  // default book geometry
  localparam int PRICE_TICKS_DEF     = 256;
  localparam int ORDERS_PER_TICK_DEF = 16;

  // field widths of the request and result words
  localparam int REQ_W    = 2;
  localparam int PRICE_W  = 8;
  localparam int VOL_W    = 24;
  localparam int TIME_W   = 32;
  localparam int ID_W     = 32;
  localparam int STATUS_W = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EXPIRE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_SMALLER = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD_PRICE   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd4;

  // one order slot as held in the slot memory
  typedef struct packed {
    logic [VOL_W-1:0]  vol;
    logic [ID_W-1:0]   ident;
    logic [TIME_W-1:0] expiry;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // level entry: head, count, live, volume
  function automatic int lvl_w(input int opt);
    return $clog2(opt) + 2 * $clog2(opt + 1) + VOL_W + $clog2(opt);
  endfunction

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_M_LRD,
    S_M_LCHK,
    S_M_SCHK,
    S_P_RD,
    S_P_CHK,
    S_R_RD,
    S_R_CHK,
    S_RS_LRD,
    S_RS_LCHK,
    S_MD_LRD,
    S_MD_LCHK,
    S_MD_SRD,
    S_MD_SCHK,
    S_EX_LRD,
    S_EX_LCHK,
    S_EX_SRD,
    S_EX_SCHK,
    S_EX_NEXT,
    S_DONE
  } state_t;

endpackage

>>> sv/lobm_req_if.sv
interface lobm_req_if;
  import lobm_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic                side;
  logic [PRICE_W-1:0]  price;
  logic [VOL_W-1:0]    volume;
  logic [TIME_W-1:0]   time_to_live;
  logic [ID_W-1:0]     order_id;
  logic [TIME_W-1:0]   current_time;

  modport source (output valid, req_type, side, price, volume, time_to_live, order_id,
                  current_time, input ready);
  modport sink (input valid, req_type, side, price, volume, time_to_live, order_id,
                current_time, output ready);
endinterface

>>> sv/lobm_res_if.sv
interface lobm_res_if;
  import lobm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VOL_W-1:0]    filled_volume;
  logic                rested;
  logic [ID_W-1:0]     new_order_id;
  logic [PRICE_W-1:0]  best_bid;
  logic [PRICE_W-1:0]  best_ask;

  modport source (output valid, status, filled_volume, rested, new_order_id, best_bid,
                  best_ask, input ready);
  modport sink (input valid, status, filled_volume, rested, new_order_id, best_bid,
                best_ask, output ready);
endinterface

>>> sv/lobm_ram.sv
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lobm_ctrl.sv
module lobm_ctrl #(
  parameter int PRICE_TICKS = lobm_pkg::PRICE_TICKS_DEF,
  parameter int ORDERS_PER_TICK = lobm_pkg::ORDERS_PER_TICK_DEF
) (
  input  logic clk,
  input  logic rst,
  lobm_req_if.sink   req,
  lobm_res_if.source res,
  output logic                                          lvl_we,
  output logic [$clog2(PRICE_TICKS):0]                  lvl_waddr,
  output logic [lobm_pkg::lvl_w(ORDERS_PER_TICK)-1:0]   lvl_wdata,
  output logic [$clog2(PRICE_TICKS):0]                  lvl_raddr,
  input  logic [lobm_pkg::lvl_w(ORDERS_PER_TICK)-1:0]   lvl_rdata,
  output logic                                          slot_we,
  output logic [$clog2(PRICE_TICKS)+$clog2(ORDERS_PER_TICK):0] slot_waddr,
  output logic [lobm_pkg::SLOT_W-1:0]                   slot_wdata,
  output logic [$clog2(PRICE_TICKS)+$clog2(ORDERS_PER_TICK):0] slot_raddr,
  input  logic [lobm_pkg::SLOT_W-1:0]                   slot_rdata
);
  import lobm_pkg::*;

  localparam int TW  = $clog2(PRICE_TICKS);
  localparam int LAW = TW + 1;
  localparam int SW  = $clog2(ORDERS_PER_TICK);
  localparam int CW  = $clog2(ORDERS_PER_TICK + 1);
  localparam int LVW = VOL_W + SW;
  localparam logic [TW-1:0] TICK_LAST = TW'(PRICE_TICKS - 1);
  localparam logic [SW-1:0] PTR_LAST  = SW'(ORDERS_PER_TICK - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(ORDERS_PER_TICK);

  state_t state, state_next;

  // latched request
  logic [REQ_W-1:0]   r_req;
  logic               r_side;
  logic [PRICE_W-1:0] r_price;
  logic [VOL_W-1:0]   r_vol;
  logic [TIME_W-1:0]  r_ttl;
  logic [ID_W-1:0]    r_oid;
  logic [TIME_W-1:0]  r_now;
  logic [TW-1:0]      tick, tick_next;
  logic [VOL_W-1:0]   rem, rem_next;

  // book state held in flops
  logic [TW-1:0] best_bid, best_bid_next, best_ask, best_ask_next;
  logic [ID_W-1:0] next_id, next_id_next;

  // working copy of the current level
  logic [LAW-1:0] cur_laddr, cur_laddr_next;
  logic [SW-1:0]  cur_head, cur_head_next;
  logic [CW-1:0]  cur_count, cur_count_next, cur_live, cur_live_next;
  logic [LVW-1:0] cur_vol, cur_vol_next;
  logic [SW-1:0]  ptr, ptr_next;
  logic [CW-1:0]  k, k_next;

  // scan and sweep position
  logic           scan_side, scan_side_next;
  logic [TW-1:0]  scan_t, scan_t_next;
  logic           exp_side, exp_side_next;
  logic [TW-1:0]  exp_t, exp_t_next;
  logic [LAW-1:0] clr, clr_next;

  // result under construction and output register
  logic [STATUS_W-1:0] w_status, w_status_next;
  logic                w_rested, w_rested_next;
  logic [ID_W-1:0]     w_newid, w_newid_next;
  logic                o_valid, o_valid_next, o_load;

  // memory read data views
  logic [SW-1:0]  l_head;
  logic [CW-1:0]  l_count, l_live;
  logic [LVW-1:0] l_vol;
  slot_t          slot_q, slot_w;

  assign {l_head, l_count, l_live, l_vol} = lvl_rdata;
  assign slot_q = slot_t'(slot_rdata);
  assign slot_wdata = slot_w;

  // decode helpers
  logic          oob, brk, pop_done, scan_found, scan_end, sid_hit, last_t;
  logic [TW-1:0] opp_best;
  logic [SW:0]   tail_sum;
  logic [SW-1:0] tail, head_inc, ptr_inc;
  logic [CW-1:0] live_dec;

  assign oob      = 32'(req.price) >= 32'(PRICE_TICKS);
  assign opp_best = r_side ? best_bid : best_ask;
  assign brk      = (l_vol == '0) || (l_count == '0) ||
                    (!r_side && (32'(opp_best) > 32'(r_price))) ||
                    (r_side && (32'(opp_best) < 32'(r_price)));
  assign pop_done = ((state == S_P_RD) && (cur_count == '0)) ||
                    ((state == S_P_CHK) && (slot_q.vol != '0));
  assign scan_found = l_live != '0;
  assign scan_end   = scan_side ? (scan_t == TICK_LAST) : (scan_t == '0);
  assign sid_hit    = (slot_q.vol != '0) && (slot_q.ident == r_oid);
  assign last_t     = exp_t == TICK_LAST;
  assign tail_sum   = (SW+1)'(l_head) + (SW+1)'(l_count);
  assign tail       = (tail_sum >= (SW+1)'(ORDERS_PER_TICK)) ?
                      SW'(tail_sum - (SW+1)'(ORDERS_PER_TICK)) : SW'(tail_sum);
  assign head_inc   = (cur_head == PTR_LAST) ? '0 : cur_head + 1'b1;
  assign ptr_inc    = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
  assign live_dec   = (cur_live != '0) ? cur_live - 1'b1 : cur_live;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (req.valid) begin
          case (req.req_type)
            REQ_SUBMIT: state_next = oob ? S_DONE : S_M_LRD;
            REQ_MODIFY: state_next = oob ? S_DONE : S_MD_LRD;
            REQ_EXPIRE: state_next = S_EX_LRD;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_M_LRD:  state_next = (rem == '0) ? S_RS_LRD : S_M_LCHK;
      S_M_LCHK: state_next = brk ? S_RS_LRD : S_M_SCHK;
      S_M_SCHK: state_next = (slot_q.vol <= rem) ? S_P_RD : S_RS_LRD;
      S_P_RD, S_P_CHK: begin
        if (pop_done) begin
          state_next = (r_req == REQ_EXPIRE) ? S_EX_NEXT : S_R_RD;
        end else begin
          state_next = (state == S_P_RD) ? S_P_CHK : S_P_RD;
        end
      end
      S_R_RD: state_next = S_R_CHK;
      S_R_CHK: begin
        if (scan_found || scan_end) begin
          if (r_req == REQ_SUBMIT) state_next = S_M_LRD;
          else if (r_req == REQ_EXPIRE && !scan_side) state_next = S_R_RD;
          else state_next = S_DONE;
        end else begin
          state_next = S_R_RD;
        end
      end
      S_RS_LRD:  state_next = (r_ttl != '0 && rem != '0) ? S_RS_LCHK : S_DONE;
      S_RS_LCHK: state_next = S_DONE;
      S_MD_LRD:  state_next = S_MD_LCHK;
      S_MD_LCHK: state_next = S_MD_SRD;
      S_MD_SRD:  state_next = (k < cur_count) ? S_MD_SCHK : S_DONE;
      S_MD_SCHK: begin
        if (sid_hit) begin
          state_next = (r_vol == '0) ? S_P_RD : S_DONE;
        end else begin
          state_next = S_MD_SRD;
        end
      end
      S_EX_LRD:  state_next = S_EX_LCHK;
      S_EX_LCHK: state_next = S_EX_SRD;
      S_EX_SRD:  state_next = (k < cur_count) ? S_EX_SCHK : S_P_RD;
      S_EX_SCHK: state_next = S_EX_SRD;
      S_EX_NEXT: state_next = (last_t && exp_side) ? S_R_RD : S_EX_LRD;
      S_DONE:    if (!o_valid || res.ready) state_next = S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    tick_next      = tick;
    rem_next       = rem;
    best_bid_next  = best_bid;
    best_ask_next  = best_ask;
    next_id_next   = next_id;
    cur_laddr_next = cur_laddr;
    cur_head_next  = cur_head;
    cur_count_next = cur_count;
    cur_live_next  = cur_live;
    cur_vol_next   = cur_vol;
    ptr_next       = ptr;
    k_next         = k;
    scan_side_next = scan_side;
    scan_t_next    = scan_t;
    exp_side_next  = exp_side;
    exp_t_next     = exp_t;
    clr_next       = clr;
    w_status_next  = w_status;
    w_rested_next  = w_rested;
    w_newid_next   = w_newid;
    o_load         = 1'b0;
    lvl_we         = 1'b0;
    lvl_waddr      = cur_laddr;
    lvl_wdata      = {cur_head, cur_count, cur_live, cur_vol};
    lvl_raddr      = cur_laddr;
    slot_we        = 1'b0;
    slot_waddr     = {cur_laddr, ptr};
    slot_w         = slot_q;
    slot_raddr     = {cur_laddr, ptr};
    req.ready      = 1'b0;

    case (state)
      // zero every level entry after reset
      S_CLEAR: begin
        lvl_we    = 1'b1;
        lvl_waddr = clr;
        lvl_wdata = '0;
        clr_next  = clr + 1'b1;
      end
      S_IDLE: begin
        req.ready     = 1'b1;
        tick_next     = TW'(req.price);
        rem_next      = req.volume;
        w_status_next = (oob && (req.req_type == REQ_SUBMIT || req.req_type == REQ_MODIFY)) ?
                        STAT_BAD_PRICE : STAT_OK;
        w_rested_next = 1'b0;
        w_newid_next  = '0;
        exp_side_next = 1'b0;
        exp_t_next    = '0;
      end
      // matching against the opposite best level
      S_M_LRD: begin
        lvl_raddr      = {~r_side, opp_best};
        cur_laddr_next = {~r_side, opp_best};
      end
      S_M_LCHK: begin
        cur_head_next  = l_head;
        cur_count_next = l_count;
        cur_live_next  = l_live;
        cur_vol_next   = l_vol;
        ptr_next       = l_head;
        slot_raddr     = {cur_laddr, l_head};
      end
      S_M_SCHK: begin
        slot_we = 1'b1;
        if (slot_q.vol <= rem) begin
          // front order consumed, pop it
          rem_next       = rem - slot_q.vol;
          slot_w.vol     = '0;
          cur_vol_next   = cur_vol - LVW'(slot_q.vol);
          cur_live_next  = live_dec;
          cur_head_next  = head_inc;
          cur_count_next = cur_count - 1'b1;
        end else begin
          slot_w.vol = slot_q.vol - rem;
          lvl_we     = 1'b1;
          lvl_wdata  = {cur_head, cur_count, cur_live, cur_vol - LVW'(rem)};
          rem_next   = '0;
        end
      end
      // drop leading holes, then write the level back
      S_P_RD, S_P_CHK: begin
        slot_raddr = {cur_laddr, cur_head};
        if (state == S_P_CHK && slot_q.vol == '0) begin
          cur_head_next  = head_inc;
          cur_count_next = cur_count - 1'b1;
        end
        if (pop_done) begin
          lvl_we = 1'b1;
          if (r_req == REQ_SUBMIT) begin
            scan_side_next = ~r_side;
            scan_t_next    = opp_best;
          end else begin
            scan_side_next = r_side;
            scan_t_next    = r_side ? best_ask : best_bid;
          end
        end
      end
      // walk away from the old best until a live level turns up or the side ends
      S_R_RD: lvl_raddr = {scan_side, scan_t};
      S_R_CHK: begin
        if (scan_found || scan_end) begin
          if (scan_side) best_ask_next = scan_found ? scan_t : TICK_LAST;
          else best_bid_next = scan_found ? scan_t : '0;
          if (r_req == REQ_EXPIRE && !scan_side) begin
            scan_side_next = 1'b1;
            scan_t_next    = best_ask;
          end
        end else begin
          scan_t_next = scan_side ? scan_t + 1'b1 : scan_t - 1'b1;
        end
      end
      // rest the remainder at the tail of its tick
      S_RS_LRD: begin
        lvl_raddr      = {r_side, tick};
        cur_laddr_next = {r_side, tick};
      end
      S_RS_LCHK: begin
        if (l_count >= CNT_FULL) begin
          w_status_next = STAT_FULL;
        end else begin
          slot_we       = 1'b1;
          slot_waddr    = {cur_laddr, tail};
          slot_w.vol    = rem;
          slot_w.ident  = next_id;
          slot_w.expiry = r_ttl;
          lvl_we        = 1'b1;
          lvl_wdata     = {l_head, l_count + 1'b1, l_live + 1'b1, l_vol + LVW'(rem)};
          w_newid_next  = next_id;
          next_id_next  = next_id + 1'b1;
          w_rested_next = 1'b1;
          if (!r_side) begin
            if (tick > best_bid) best_bid_next = tick;
          end else begin
            if (tick < best_ask) best_ask_next = tick;
          end
        end
      end
      // modify and expire: read the level; modify then searches the tick's queue for the id
      S_MD_LRD, S_EX_LRD: begin
        lvl_raddr      = (state == S_MD_LRD) ? {r_side, tick} : {exp_side, exp_t};
        cur_laddr_next = (state == S_MD_LRD) ? {r_side, tick} : {exp_side, exp_t};
      end
      S_MD_LCHK, S_EX_LCHK: begin
        cur_head_next  = l_head;
        cur_count_next = l_count;
        cur_live_next  = l_live;
        cur_vol_next   = l_vol;
        ptr_next       = l_head;
        k_next         = '0;
        if (state == S_MD_LCHK) w_status_next = STAT_NOT_FOUND;
      end
      S_MD_SCHK: begin
        if (sid_hit) begin
          if (r_vol <= slot_q.vol) begin
            w_status_next = STAT_OK;
            slot_we       = 1'b1;
            slot_w.vol    = r_vol;
            if (r_vol == '0) begin
              cur_vol_next  = cur_vol - LVW'(slot_q.vol);
              cur_live_next = live_dec;
            end else begin
              lvl_we    = 1'b1;
              lvl_wdata = {cur_head, cur_count, cur_live,
                           cur_vol - LVW'(slot_q.vol - r_vol)};
            end
          end else begin
            w_status_next = STAT_NOT_SMALLER;
          end
        end else begin
          k_next   = k + 1'b1;
          ptr_next = ptr_inc;
        end
      end
      // expire: kill every live slot that is due
      S_EX_SCHK: begin
        if (slot_q.vol != '0 && slot_q.expiry <= r_now) begin
          slot_we       = 1'b1;
          slot_w.vol    = '0;
          cur_vol_next  = cur_vol - LVW'(slot_q.vol);
          cur_live_next = live_dec;
        end
        k_next   = k + 1'b1;
        ptr_next = ptr_inc;
      end
      S_EX_NEXT: begin
        if (last_t) begin
          exp_t_next = '0;
          if (!exp_side) begin
            exp_side_next = 1'b1;
          end else begin
            scan_side_next = 1'b0;
            scan_t_next    = best_bid;
          end
        end else begin
          exp_t_next = exp_t + 1'b1;
        end
      end
      S_DONE: o_load = !o_valid || res.ready;
      default: ;
    endcase
  end

  assign o_valid_next = (o_valid && !res.ready) || o_load;
  assign res.valid    = o_valid;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      o_valid  <= 1'b0;
      best_bid <= '0;
      best_ask <= TICK_LAST;
      next_id  <= '0;
    end else begin
      state    <= state_next;
      clr      <= clr_next;
      o_valid  <= o_valid_next;
      best_bid <= best_bid_next;
      best_ask <= best_ask_next;
      next_id  <= next_id_next;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      r_req   <= req.req_type;
      r_side  <= req.side;
      r_price <= req.price;
      r_vol   <= req.volume;
      r_ttl   <= req.time_to_live;
      r_oid   <= req.order_id;
      r_now   <= req.current_time;
    end
    tick      <= tick_next;
    rem       <= rem_next;
    cur_laddr <= cur_laddr_next;
    cur_head  <= cur_head_next;
    cur_count <= cur_count_next;
    cur_live  <= cur_live_next;
    cur_vol   <= cur_vol_next;
    ptr       <= ptr_next;
    k         <= k_next;
    scan_side <= scan_side_next;
    scan_t    <= scan_t_next;
    exp_side  <= exp_side_next;
    exp_t     <= exp_t_next;
    w_status  <= w_status_next;
    w_rested  <= w_rested_next;
    w_newid   <= w_newid_next;
    if (o_load) begin
      res.status        <= w_status;
      res.filled_volume <= (r_req == REQ_SUBMIT) ? r_vol - rem : '0;
      res.rested        <= w_rested;
      res.new_order_id  <= w_newid;
      res.best_bid      <= PRICE_W'(best_bid);
      res.best_ask      <= PRICE_W'(best_ask);
    end
  end

endmodule

>>> sv/limit_order_book_matcher.sv
// Limit order book matcher, one instrument, price-time priority.
// req carries one request word (submit, modify/cancel, expire); res returns
// exactly one status word per request, in order. Both are valid/ready.
// A request is taken only while the engine is idle; the result sits in an
// output register, so the next request is taken while it waits on a stalled
// receiver, and that request's result is held back until the register frees.
// A submit matches resting orders one at a time, popping holes and walking
// further ticks when a best level empties; a modify searches its tick's
// slots one by one, a cancel adding the pop and the walk; expire visits
// every tick of both sides, slot by slot, and pops holes. The engine goes
// back to idle between requests. The level and slot memories each have a
// single read port, one access a cycle, and the read is registered.
// After reset the level memory is cleared, one entry a cycle, all 2*2^clog2(
// PRICE_TICKS) entries (512 by default), with req.ready low; the slot memory
// is never cleared, as only slots inside a queue are read.
// best_bid reads 0 with no bids, best_ask the top tick with no asks.
module limit_order_book_matcher #(
  parameter int PRICE_TICKS = lobm_pkg::PRICE_TICKS_DEF,
  parameter int ORDERS_PER_TICK = lobm_pkg::ORDERS_PER_TICK_DEF
) (
  input  logic clk,
  input  logic rst,
  lobm_req_if.sink   req,
  lobm_res_if.source res
);
  import lobm_pkg::*;

  localparam int LAW = $clog2(PRICE_TICKS) + 1;
  localparam int SAW = LAW + $clog2(ORDERS_PER_TICK);
  localparam int LW  = lvl_w(ORDERS_PER_TICK);

  logic           lvl_we, slot_we;
  logic [LAW-1:0] lvl_waddr, lvl_raddr;
  logic [LW-1:0]  lvl_wdata, lvl_rdata;
  logic [SAW-1:0] slot_waddr, slot_raddr;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata;

  // sequencer
  lobm_ctrl #(
    .PRICE_TICKS(PRICE_TICKS),
    .ORDERS_PER_TICK(ORDERS_PER_TICK)
  ) u_ctrl (
    .clk(clk), .rst(rst), .req(req), .res(res),
    .lvl_we(lvl_we), .lvl_waddr(lvl_waddr), .lvl_wdata(lvl_wdata),
    .lvl_raddr(lvl_raddr), .lvl_rdata(lvl_rdata),
    .slot_we(slot_we), .slot_waddr(slot_waddr), .slot_wdata(slot_wdata),
    .slot_raddr(slot_raddr), .slot_rdata(slot_rdata)
  );

  // per-level head, count, live count and volume
  lobm_ram #(.WIDTH(LW), .ADDR_W(LAW)) u_lvl_ram (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  // order slots
  lobm_ram #(.WIDTH(SLOT_W), .ADDR_W(SAW)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

endmodule

>>> sv/lobm_checker.sv
module lobm_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  status,
  input logic [23:0] filled,
  input logic        rested,
  input logic [31:0] new_order_id
);
  import lobm_pkg::*;

  // a pending word stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  // a rested order always reports success
  a_rest_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && rested |-> status == STAT_OK)
    else $error("rested with non-ok status");

  // no id without a rested order
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !rested |-> new_order_id == '0)
    else $error("order id given without resting");

  // a rejected price neither fills nor rests
  a_bad_price: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == STAT_BAD_PRICE |-> filled == '0 && !rested)
    else $error("bad price request touched the book");

  // the clearing pass takes no request at its start, just after reset
  a_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("request taken during clearing pass");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready),
  .status(res.status), .filled(res.filled_volume), .rested(res.rested),
  .new_order_id(res.new_order_id)
);

>>> tb/limit_order_book_matcher_tb.sv
module limit_order_book_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lobm_pkg::*;

  localparam int TICKS      = PRICE_TICKS_DEF;
  localparam int DEPTH      = ORDERS_PER_TICK_DEF;
  localparam int RAND_ITEMS = 1320;
  localparam int LIMIT      = 3_000_000;
  localparam int DRAIN      = 3000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef struct {
    logic [REQ_W-1:0]   kind;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   vol;
    logic [TIME_W-1:0]  ttl;
    logic [ID_W-1:0]    oid;
    logic [TIME_W-1:0]  now;
  } order_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VOL_W-1:0]    filled;
    logic                rested;
    logic [ID_W-1:0]     new_id;
    logic [PRICE_W-1:0]  bid;
    logic [PRICE_W-1:0]  ask;
  } book_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lobm_req_if req ();
  lobm_res_if res ();

  limit_order_book_matcher uut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .res(res.source)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow copy of the book
  logic [VOL_W-1:0]  slot_vol [2][TICKS][DEPTH];
  logic [ID_W-1:0]   slot_id  [2][TICKS][DEPTH];
  logic [TIME_W-1:0] slot_exp [2][TICKS][DEPTH];
  int unsigned       head     [2][TICKS];
  int unsigned       cnt      [2][TICKS];
  int unsigned       live     [2][TICKS];
  longint unsigned   lvl_vol  [2][TICKS];
  int unsigned       best     [2];
  logic [ID_W-1:0]   next_id;
  // where each rested id was placed, for picking modify targets
  bit                id_side  [int unsigned];
  int unsigned       id_price [int unsigned];

  book_res_t  expected_q [$];
  order_req_t pend_q [$];

  int sent_cnt = 0, got_cnt = 0, errors = 0;
  int n_fills = 0, n_full = 0, n_mod_ok = 0, n_mod_bad = 0, n_expire = 0;
  bit sender_quiet = 1'b0;

  function automatic void kill_order(int s, int t, int k);
    lvl_vol[s][t] -= slot_vol[s][t][k];
    slot_vol[s][t][k] = '0;
    if (live[s][t] > 0) live[s][t]--;
  endfunction

  function automatic void drop_holes(int s, int t);
    while (cnt[s][t] > 0 && slot_vol[s][t][head[s][t]] == 0) begin
      head[s][t] = (head[s][t] + 1) % DEPTH;
      cnt[s][t]--;
    end
  endfunction

  function automatic void find_best(int s);
    if (s == SIDE_BID) begin
      best[0] = 0;
      for (int t = TICKS - 1; t >= 0; t--)
        if (live[0][t] > 0) begin
          best[0] = t;
          break;
        end
    end else begin
      best[1] = TICKS - 1;
      for (int t = 0; t < TICKS; t++)
        if (live[1][t] > 0) begin
          best[1] = t;
          break;
        end
    end
  endfunction

  function automatic void clear_book();
    for (int s = 0; s < 2; s++)
      for (int t = 0; t < TICKS; t++) begin
        head[s][t] = 0;
        cnt[s][t] = 0;
        live[s][t] = 0;
        lvl_vol[s][t] = 0;
        for (int k = 0; k < DEPTH; k++) begin
          slot_vol[s][t][k] = '0;
          slot_id[s][t][k] = '0;
          slot_exp[s][t][k] = '0;
        end
      end
    best[0] = 0;
    best[1] = TICKS - 1;
    next_id = '0;
  endfunction

  // apply one request to the shadow book and return the status word
  function automatic book_res_t match_order(order_req_t r);
    book_res_t o;
    int s, opp, b, t, k;
    logic [VOL_W-1:0] rem, fv;
    o = '{default: '0};
    s = r.side;
    t = r.price;
    case (r.kind)
      REQ_SUBMIT: begin
        opp = 1 - s;
        rem = r.vol;
        while (rem != 0) begin
          b = best[opp];
          if (lvl_vol[opp][b] == 0 || cnt[opp][b] == 0) break;
          if (s == SIDE_BID && b > t) break;
          if (s == SIDE_ASK && b < t) break;
          k = head[opp][b];
          fv = slot_vol[opp][b][k];
          if (fv <= rem) begin
            rem -= fv;
            kill_order(opp, b, k);
            drop_holes(opp, b);
          end else begin
            slot_vol[opp][b][k] = fv - rem;
            lvl_vol[opp][b] -= rem;
            rem = '0;
          end
          find_best(opp);
        end
        o.filled = r.vol - rem;
        if (r.ttl != 0 && rem != 0) begin
          if (cnt[s][t] >= DEPTH) begin
            o.status = STAT_FULL;
          end else begin
            k = (head[s][t] + cnt[s][t]) % DEPTH;
            slot_vol[s][t][k] = rem;
            slot_exp[s][t][k] = r.ttl;
            slot_id[s][t][k] = next_id;
            o.new_id = next_id;
            o.rested = 1'b1;
            id_side[next_id] = s;
            id_price[next_id] = t;
            next_id++;
            cnt[s][t]++;
            live[s][t]++;
            lvl_vol[s][t] += rem;
            find_best(s);
          end
        end
      end
      REQ_MODIFY: begin
        o.status = STAT_NOT_FOUND;
        for (int j = 0; j < cnt[s][t]; j++) begin
          k = (head[s][t] + j) % DEPTH;
          if (slot_vol[s][t][k] != 0 && slot_id[s][t][k] == r.oid) begin
            if (r.vol <= slot_vol[s][t][k]) begin
              if (r.vol == 0) begin
                kill_order(s, t, k);
                drop_holes(s, t);
              end else begin
                lvl_vol[s][t] -= slot_vol[s][t][k] - r.vol;
                slot_vol[s][t][k] = r.vol;
              end
              find_best(s);
              o.status = STAT_OK;
            end else begin
              o.status = STAT_NOT_SMALLER;
            end
            break;
          end
        end
      end
      REQ_EXPIRE: begin
        for (int si = 0; si < 2; si++) begin
          for (int ti = 0; ti < TICKS; ti++) begin
            for (int j = 0; j < cnt[si][ti]; j++) begin
              k = (head[si][ti] + j) % DEPTH;
              if (slot_vol[si][ti][k] != 0 && slot_exp[si][ti][k] <= r.now)
                kill_order(si, ti, k);
            end
            drop_holes(si, ti);
          end
          find_best(si);
        end
      end
      default: ;
    endcase
    o.bid = best[0][PRICE_W-1:0];
    o.ask = best[1][PRICE_W-1:0];
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (sender_quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 8);
  endfunction

  function automatic order_req_t make_req(logic [REQ_W-1:0] kind, logic side, int price,
                                         logic [VOL_W-1:0] vol, logic [TIME_W-1:0] ttl,
                                         logic [ID_W-1:0] oid, logic [TIME_W-1:0] now);
    order_req_t r;
    r.kind = kind;
    r.side = side;
    r.price = price[PRICE_W-1:0];
    r.vol = vol;
    r.ttl = ttl;
    r.oid = oid;
    r.now = now;
    return r;
  endfunction

  // request driver
  int gap_left = 0;
  order_req_t cur;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.req_type <= '0;
      req.side <= 1'b0;
      req.price <= '0;
      req.volume <= '0;
      req.time_to_live <= '0;
      req.order_id <= '0;
      req.current_time <= '0;
    end else begin
      if (req.valid && req.ready) begin
        expected_q.push_back(match_order(cur));
        sent_cnt++;
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          cur = pend_q.pop_front();
          req.req_type <= cur.kind;
          req.side <= cur.side;
          req.price <= cur.price;
          req.volume <= cur.vol;
          req.time_to_live <= cur.ttl;
          req.order_id <= cur.oid;
          req.current_time <= cur.now;
          req.valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, to back the block up
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_cnt >= 400) begin
      hold_left <= 6000;
      hold_done <= 1'b1;
    end
  end

  // result monitor and receiver stalls
  int stall_left = 0;
  book_res_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got = '{res.status, res.filled_volume, res.rested, res.new_order_id,
                res.best_bid, res.best_ask};
        got_cnt++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %0d: %p", got_cnt, got);
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status || got.filled != want.filled ||
              got.rested != want.rested || got.new_id != want.new_id ||
              got.bid != want.bid || got.ask != want.ask) begin
            errors++;
            if (errors <= 10)
              $display("mismatch on result word %0d: expected %p, got %p", got_cnt, want, got);
          end
          if (want.filled != 0) n_fills++;
          if (want.status == STAT_FULL) n_full++;
        end
      end
      if (hold_left > 0) begin
        res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               expected_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [TIME_W-1:0] now;
    int r, id, p;
    order_req_t q;
    clear_book();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, market orders, modify cases, expiry, full tick
    pend_q.push_back(make_req(REQ_SUBMIT, SIDE_BID, 0, 24'hFFFFFF, 32'hFFFFFFFF, 0, 0));
    pend_q.push_back(make_req(REQ_SUBMIT, SIDE_ASK, 255, 1, 1, 0, 0));
    pend_q.push_back(make_req(REQ_SUBMIT, SIDE_ASK, 0, 24'hFFFFFF, 0, 32'hFFFFFFFF, 0));
    pend_q.push_back(make_req(REQ_SUBMIT, SIDE_BID, 255, 0, 5, 0, 0));
    pend_q.push_back(make_req(REQ_SUBMIT, SIDE_BID, 255, 3, 0, 0, 0));
    pend_q.push_back(make_req(REQ_SUBMIT, SIDE_BID, 120, 100, 50, 0, 0));
    pend_q.push_back(make_req(REQ_MODIFY, SIDE_BID, 120, 100, 0, 2, 0));
    pend_q.push_back(make_req(REQ_MODIFY, SIDE_BID, 120, 101, 0, 2, 0));
    pend_q.push_back(make_req(REQ_MODIFY, SIDE_BID, 120, 5, 0, 12345, 0));
    pend_q.push_back(make_req(REQ_MODIFY, SIDE_BID, 120, 40, 0, 2, 0));
    pend_q.push_back(make_req(REQ_SUBMIT, SIDE_BID, 120, 10, 60, 0, 0));
    pend_q.push_back(make_req(REQ_MODIFY, SIDE_BID, 120, 0, 0, 2, 0));
    pend_q.push_back(make_req(REQ_EXPIRE, SIDE_ASK, 255, 24'hFFFFFF, 0, 0, 60));
    pend_q.push_back(make_req(REQ_UNUSED, SIDE_ASK, 255, 24'hFFFFFF, 32'hFFFFFFFF,
                              32'hFFFFFFFF, 32'hFFFFFFFF));
    for (int i = 0; i < DEPTH + 1; i++)
      pend_q.push_back(make_req(REQ_SUBMIT, SIDE_ASK, 200, 7, 1000, 0, 0));
    pend_q.push_back(make_req(REQ_EXPIRE, SIDE_BID, 0, 0, 0, 0, 32'hFFFFFFFF));

    // random traffic around a busy price band
    now = 100;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      while (pend_q.size() > 6) @(posedge clk);
      if (i % 200 == 0) sender_quiet = ($urandom_range(2) == 0);
      now += $urandom_range(3);
      r = $urandom_range(99);
      p = ($urandom_range(9) == 0) ? $urandom_range(TICKS - 1) : $urandom_range(145, 110);
      q = make_req(REQ_SUBMIT, 1'($urandom_range(1)), p, VOL_W'($urandom_range(200, 1)),
                   now + $urandom_range(400, 1), $urandom, $urandom);
      if (r < 58) begin
        case ($urandom_range(19))
          0: q.ttl = '0;
          1: q.ttl = $urandom;
          2: q.vol = VOL_W'($urandom);
          3: q.vol = '0;
          default: ;
        endcase
      end else if (r < 90) begin
        q.kind = REQ_MODIFY;
        q.vol = ($urandom_range(6) == 0) ? '0 : VOL_W'($urandom_range(220));
        if (next_id != 0 && $urandom_range(9) != 0) begin
          id = next_id - 1 - $urandom_range(next_id > 30 ? 30 : next_id - 1);
          if (id_side.exists(id)) begin
            q.oid = id;
            q.side = id_side[id];
            q.price = id_price[id][PRICE_W-1:0];
          end
        end
        if ($urandom_range(15) == 0) q.vol = VOL_W'($urandom);
      end else if (r < 96) begin
        q.kind = REQ_EXPIRE;
        q.now = ($urandom_range(24) == 0) ? $urandom : now;
        n_expire++;
      end else begin
        q.kind = REQ_UNUSED;
      end
      pend_q.push_back(q);
    end

    // drain
    while (pend_q.size() > 0 || req.valid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d with fills, %0d full-tick rejects,",
             sent_cnt, got_cnt, n_fills, n_full);
    $display("%0d expiry sweeps, one long receiver hold-off; %0d errors", n_expire, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
